FILE: src/mlr_pkg.sv
// Shared constants, types and command/status structs for the midpoint line rasterizer.
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS = 6;
    localparam int PIX_BITS   = 6;
    localparam int COLOR_BITS = 32;
    localparam int DEC_BITS   = COORD_BITS + 4;

    typedef logic signed [DEC_BITS-1:0] t_dec;

    typedef enum logic [2:0] {
        MODE_HORZ      = 3'd0,
        MODE_VERT      = 3'd1,
        MODE_POS_SHAL  = 3'd2,
        MODE_POS_STEEP = 3'd3,
        MODE_NEG_SHAL  = 3'd4,
        MODE_NEG_STEEP = 3'd5
    } t_mode;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/mlr_if.sv
// Valid/ready channel interfaces for line requests and pixel results.
`default_nettype none

interface mlr_line_if;
    logic                            valid;
    logic                            ready;
    logic [mlr_pkg::PIX_BITS-1:0]    start_x;
    logic [mlr_pkg::PIX_BITS-1:0]    start_y;
    logic [mlr_pkg::PIX_BITS-1:0]    end_x;
    logic [mlr_pkg::PIX_BITS-1:0]    end_y;
    logic [mlr_pkg::COLOR_BITS-1:0]  line_color;

    modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface mlr_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [mlr_pkg::PIX_BITS-1:0]    pixel_x;
    logic [mlr_pkg::PIX_BITS-1:0]    pixel_y;
    logic [mlr_pkg::COLOR_BITS-1:0]  pixel_color;
    logic                            last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

FILE: src/mlr_datapath.sv
// Datapath: endpoint ordering, octant setup and incremental midpoint stepping.
`default_nettype none

module mlr_datapath (
    input  wire                              i_clk,
    input  wire mlr_pkg::t_cmd               i_cmd,
    output mlr_pkg::t_sts                    o_sts,
    input  wire [mlr_pkg::PIX_BITS-1:0]      i_start_x,
    input  wire [mlr_pkg::PIX_BITS-1:0]      i_start_y,
    input  wire [mlr_pkg::PIX_BITS-1:0]      i_end_x,
    input  wire [mlr_pkg::PIX_BITS-1:0]      i_end_y,
    input  wire [mlr_pkg::COLOR_BITS-1:0]    i_color,
    output logic [mlr_pkg::COORD_BITS-1:0]   o_x,
    output logic [mlr_pkg::COORD_BITS-1:0]   o_y,
    output logic [mlr_pkg::COLOR_BITS-1:0]   o_color
);

    logic [mlr_pkg::COORD_BITS-1:0]  r_x, n_x;
    logic [mlr_pkg::COORD_BITS-1:0]  r_y, n_y;
    logic [mlr_pkg::COORD_BITS-1:0]  r_cnt, n_cnt;
    mlr_pkg::t_dec                   r_d, n_d;
    mlr_pkg::t_dec                   r_a2, n_a2;
    mlr_pkg::t_dec                   r_b2, n_b2;
    mlr_pkg::t_mode                  r_mode, n_mode;
    logic [mlr_pkg::COLOR_BITS-1:0]  r_color, n_color;

    logic [mlr_pkg::COORD_BITS-1:0]  x1, y1, x2, y2;
    logic [mlr_pkg::COORD_BITS-1:0]  px1, py1, px2, py2, qy1, qy2;
    logic [mlr_pkg::COORD_BITS-1:0]  dx, dy;
    logic                            vert, horz, up, shallow;
    mlr_pkg::t_dec                   a, b;
    mlr_pkg::t_mode                  s_mode;
    logic [mlr_pkg::COORD_BITS-1:0]  s_cnt;
    mlr_pkg::t_dec                   s_d;

    always_comb begin
        x1 = mlr_pkg::COORD_BITS'(i_start_x);
        y1 = mlr_pkg::COORD_BITS'(i_start_y);
        x2 = mlr_pkg::COORD_BITS'(i_end_x);
        y2 = mlr_pkg::COORD_BITS'(i_end_y);

        if (x2 < x1) begin
            px1 = x2; py1 = y2; px2 = x1; py2 = y1;
        end else begin
            px1 = x1; py1 = y1; px2 = x2; py2 = y2;
        end
        vert = (px1 == px2);
        if (vert && (py2 < py1)) begin
            qy1 = py2; qy2 = py1;
        end else begin
            qy1 = py1; qy2 = py2;
        end
        horz    = (qy1 == qy2);
        up      = (qy2 > qy1);
        dx      = px2 - px1;
        dy      = up ? (qy2 - qy1) : (qy1 - qy2);
        shallow = (dy < dx);

        a = mlr_pkg::t_dec'(qy1) - mlr_pkg::t_dec'(qy2);
        b = mlr_pkg::t_dec'(px2) - mlr_pkg::t_dec'(px1);

        if (vert) begin
            s_mode = mlr_pkg::MODE_VERT;
        end else if (horz) begin
            s_mode = mlr_pkg::MODE_HORZ;
        end else if (up) begin
            s_mode = shallow ? mlr_pkg::MODE_POS_SHAL : mlr_pkg::MODE_POS_STEEP;
        end else begin
            s_mode = shallow ? mlr_pkg::MODE_NEG_SHAL : mlr_pkg::MODE_NEG_STEEP;
        end

        case (s_mode)
            mlr_pkg::MODE_HORZ: begin
                s_cnt = dx;
                s_d   = '0;
            end
            mlr_pkg::MODE_VERT: begin
                s_cnt = dy;
                s_d   = '0;
            end
            mlr_pkg::MODE_POS_SHAL: begin
                s_cnt = dx;
                s_d   = (a <<< 1) + b;
            end
            mlr_pkg::MODE_POS_STEEP: begin
                s_cnt = dy;
                s_d   = a + (b <<< 1);
            end
            mlr_pkg::MODE_NEG_SHAL: begin
                s_cnt = dx;
                s_d   = (a <<< 1) - b;
            end
            default: begin
                s_cnt = dy;
                s_d   = a - (b <<< 1);
            end
        endcase
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_a2    = r_a2;
        n_b2    = r_b2;
        n_mode  = r_mode;
        n_color = r_color;
        if (i_cmd.load) begin
            n_x     = px1;
            n_y     = qy1;
            n_cnt   = s_cnt;
            n_d     = s_d;
            n_a2    = a <<< 1;
            n_b2    = b <<< 1;
            n_mode  = s_mode;
            n_color = i_color;
        end else if (i_cmd.step) begin
            n_cnt = r_cnt - 1'b1;
            case (r_mode)
                mlr_pkg::MODE_HORZ: begin
                    n_x = r_x + 1'b1;
                end
                mlr_pkg::MODE_VERT: begin
                    n_y = r_y + 1'b1;
                end
                mlr_pkg::MODE_POS_SHAL: begin
                    n_x = r_x + 1'b1;
                    if (r_d < 0) begin
                        n_y = r_y + 1'b1;
                        n_d = r_d + r_a2 + r_b2;
                    end else begin
                        n_d = r_d + r_a2;
                    end
                end
                mlr_pkg::MODE_POS_STEEP: begin
                    n_y = r_y + 1'b1;
                    if (r_d > 0) begin
                        n_x = r_x + 1'b1;
                        n_d = r_d + r_a2 + r_b2;
                    end else begin
                        n_d = r_d + r_b2;
                    end
                end
                mlr_pkg::MODE_NEG_SHAL: begin
                    n_x = r_x + 1'b1;
                    if (r_d > 0) begin
                        n_y = r_y - 1'b1;
                        n_d = r_d + r_a2 - r_b2;
                    end else begin
                        n_d = r_d + r_a2;
                    end
                end
                default: begin
                    n_y = r_y - 1'b1;
                    if (r_d < 0) begin
                        n_x = r_x + 1'b1;
                        n_d = r_d + r_a2 - r_b2;
                    end else begin
                        n_d = r_d - r_b2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_cnt   <= n_cnt;
        r_d     <= n_d;
        r_a2    <= n_a2;
        r_b2    <= n_b2;
        r_mode  <= n_mode;
        r_color <= n_color;
    end

    assign o_sts.last = (r_cnt == '0);
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_color    = r_color;

endmodule

`default_nettype wire

FILE: src/mlr_ctrl.sv
// Controller: accepts line requests and sequences pixel output.
`default_nettype none

module mlr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire mlr_pkg::t_sts  i_sts,
    output mlr_pkg::t_cmd       o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;
    logic   out_fire;

    always_comb begin
        out_fire    = (r_state == ST_RUN) && i_out_ready;
        o_out_valid = (r_state == ST_RUN);
        o_in_ready  = (r_state == ST_IDLE) || (out_fire && i_sts.last);
        o_cmd.load  = i_in_valid && o_in_ready;
        o_cmd.step  = out_fire && !i_sts.last;

        case (r_state)
            ST_IDLE: n_state = o_cmd.load ? ST_RUN : ST_IDLE;
            ST_RUN:  n_state = (i_sts.last && out_fire && !o_cmd.load) ? ST_IDLE : ST_RUN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_load_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RUN))
        else $error("load did not start a run");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && !i_out_ready |=> (r_state == ST_RUN))
        else $error("run dropped while output stalled");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && i_sts.last && !o_cmd.load |=> (r_state == ST_IDLE))
        else $error("run continued past last pixel");

    a_no_load_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && !(out_fire && i_sts.last) |-> !o_cmd.load)
        else $error("request taken during a run");
`endif

endmodule

`default_nettype wire

FILE: src/midpoint_line_rasterizer_core.sv
// Top level of the midpoint line rasterizer: controller plus datapath.
//
// Usage:
//   i_line carries one request per line: two endpoints and a color.
//   o_pixel returns the pixels of that line in order, one per transfer,
//   with last_pixel set on the final one. A line of n pixels (n is its
//   major-axis length plus one, 1 to 64) gives n transfers.
//   The first pixel is presented in the cycle after the request is
//   taken. Throughput: one pixel per cycle while o_pixel.ready is high,
//   set by the single decision accumulator that updates once per pixel.
//   The next request is taken in the same cycle the last pixel is taken,
//   so back-to-back lines follow each other without a gap.
//   Reset (synchronous, active low) returns the block to idle; any line in
//   progress is dropped.
//   When the receiver stalls, the current pixel holds on o_pixel and no
//   new request is taken until the line's last pixel is taken.
`default_nettype none

module midpoint_line_rasterizer_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mlr_line_if.sink      i_line,
    mlr_pixel_if.source   o_pixel
);

    mlr_pkg::t_cmd                   cmd;
    mlr_pkg::t_sts                   sts;
    logic [mlr_pkg::COORD_BITS-1:0]  pix_x;
    logic [mlr_pkg::COORD_BITS-1:0]  pix_y;

    mlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .o_in_ready  (i_line.ready),
        .o_out_valid (o_pixel.valid),
        .i_out_ready (o_pixel.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mlr_datapath u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_start_x (i_line.start_x),
        .i_start_y (i_line.start_y),
        .i_end_x   (i_line.end_x),
        .i_end_y   (i_line.end_y),
        .i_color   (i_line.line_color),
        .o_x       (pix_x),
        .o_y       (pix_y),
        .o_color   (o_pixel.pixel_color)
    );

    assign o_pixel.pixel_x    = mlr_pkg::PIX_BITS'(pix_x);
    assign o_pixel.pixel_y    = mlr_pkg::PIX_BITS'(pix_y);
    assign o_pixel.last_pixel = sts.last;

endmodule

`default_nettype wire
